// ===== hdl/hptdq_pkg.sv =====
// Shared constants, types and the noise generator step for the dither requantiser.
package hptdq_pkg;

  localparam int DITHER_DELAY_DEF = 4;

  localparam int SAMPLE_W = 32;
  localparam int LEVEL_W  = 25;
  localparam int QSCALE_W = 40;
  localparam int RECIP_W  = 46;
  localparam int WORD_W   = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 46;

  localparam logic [CFG_INDEX_W-1:0] REG_QUANT_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OUT_RECIP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRNG_SEED   = 2'd2;

  localparam logic [QSCALE_W-1:0] QSCALE_RESET = 40'd549755813888;
  localparam logic [RECIP_W-1:0]  RECIP_RESET  = 46'd33554432;
  localparam logic [WORD_W-1:0]   SEED_RESET   = 32'd16386;

  // 1.18e-17 * 2^79, rounded
  localparam int                SUBST_W    = 23;
  localparam logic [SUBST_W-1:0] SUBST_MULT = 23'd7132662;

  // serial multiplier: signed multiplicand, unsigned multiplier, one bit a cycle
  localparam int MCAND_W  = 40;
  localparam int MPLIER_W = 46;
  localparam int ACC_W    = MCAND_W + MPLIER_W + 1;
  localparam int CNT_W    = 6;

  localparam logic [CNT_W-1:0] N_SUBST  = 6'd23;
  localparam logic [CNT_W-1:0] N_QSCALE = 6'd40;
  localparam logic [CNT_W-1:0] N_RECIP  = 6'd46;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 25'h0FF_FFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MIN = 25'h100_0000;

  localparam logic [SAMPLE_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] OUT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic [WORD_W-1:0] xorshift32(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w ^ (w << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

endpackage

// ===== hdl/hptdq_serial_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand by unsigned multiplier, LSB first.
module hptdq_serial_mul
  import hptdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MCAND_W-1:0] mcand,
  input  logic [MPLIER_W-1:0]       mplier,
  input  logic [CNT_W-1:0]          nbits,
  output mul_stat_t                 stat,
  output logic [ACC_W-1:0]          acc
);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [MCAND_W:0]    hi;
  logic [MPLIER_W-1:0] lo;
  logic [MCAND_W-1:0]  mc;
  logic [MCAND_W:0]    sum;

  assign sum = hi + (lo[0] ? {mc[MCAND_W-1], mc} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= mplier;
      mc <= mcand;
    end else if (busy) begin
      hi <= {sum[MCAND_W], sum[MCAND_W:1]};
      lo <= {sum[0], lo[MPLIER_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign acc       = {hi, lo};

endmodule

// ===== hdl/highpass_tpdf_dither_quantizer_unit.sv =====
// Top level of the high-passed TPDF dither requantiser.
// One sample is in flight at a time: the next sample is taken only once the
// result of the last has been loaded into the result register. A single
// bit-serial shift-add multiplier, one multiplier bit per cycle, forms the
// scaled sample (40 bits), the zero-sample substitute (23 bits, then 40) and the
// output scaling (46 bits) in turn. The result register holds one finished result
// while the next sample is taken. Register writes take effect at once; writing the
// seed also reloads the noise generator.
module highpass_tpdf_dither_quantizer_unit
  import hptdq_pkg::*;
#(
  parameter int DITHER_DELAY = DITHER_DELAY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic signed [LEVEL_W-1:0]  quant_level
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_S = 3'd1;
  localparam logic [2:0] ST_MUL_Z = 3'd2;
  localparam logic [2:0] ST_MUL_T = 3'd3;
  localparam logic [2:0] ST_SCALE = 3'd4;
  localparam logic [2:0] ST_MUL_O = 3'd5;
  localparam logic [2:0] ST_WB    = 3'd6;

  localparam int SUM_W = 74;

  logic [2:0]          state;
  logic [QSCALE_W-1:0] quant_scale;
  logic [RECIP_W-1:0]  out_scale_recip;
  logic [WORD_W-1:0]   noise_word;
  logic [WORD_W-1:0]   hist [DITHER_DELAY];
  logic [WORD_W:0]     dither_diff;
  logic [LEVEL_W-1:0]  level;

  logic [WORD_W-1:0]   word_next;
  logic [WORD_W:0]     diff_next;
  logic                accept;
  logic                out_load;

  logic                mul_start;
  logic [MCAND_W-1:0]  mul_mcand;
  logic [MPLIER_W-1:0] mul_mplier;
  logic [CNT_W-1:0]    mul_nbits;
  mul_stat_t           mul_stat;
  logic [ACC_W-1:0]    acc;

  logic [SUM_W-1:0]    sum_a;
  logic [SUM_W-1:0]    level_sum;
  logic [26:0]         level_raw;
  logic [LEVEL_W-1:0]  level_sat;
  logic [71:0]         out_rnd;
  logic [54:0]         out_raw;
  logic [SAMPLE_W-1:0] out_sat;

  hptdq_serial_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .nbits  (mul_nbits),
    .stat   (mul_stat),
    .acc    (acc)
  );

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_load     = (state == ST_WB) && (!result_valid || !result_stall);

  assign word_next = xorshift32(noise_word);
  assign diff_next = {1'b0, word_next} - {1'b0, hist[DITHER_DELAY-1]};

  // multiplier operand selection
  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_nbits  = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          mul_start = 1'b1;
          if (sample_in != '0) begin
            mul_mcand  = {{(MCAND_W-SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};
            mul_mplier = {{(MPLIER_W-QSCALE_W){1'b0}}, quant_scale};
            mul_nbits  = N_QSCALE;
          end else begin
            mul_mcand  = {{(MCAND_W-WORD_W){1'b0}}, noise_word};
            mul_mplier = {{(MPLIER_W-SUBST_W){1'b0}}, SUBST_MULT};
            mul_nbits  = N_SUBST;
          end
        end
      end
      ST_MUL_Z: begin
        if (mul_stat.done) begin
          // substitute sample z, units of 2^-63
          mul_start  = 1'b1;
          mul_mcand  = {1'b0, acc[77:39]};
          mul_mplier = {{(MPLIER_W-QSCALE_W){1'b0}}, quant_scale};
          mul_nbits  = N_QSCALE;
        end
      end
      ST_SCALE: begin
        mul_start  = 1'b1;
        mul_mcand  = {{(MCAND_W-LEVEL_W){level[LEVEL_W-1]}}, level};
        mul_mplier = out_scale_recip;
        mul_nbits  = N_RECIP;
      end
      default: ;
    endcase
  end

  // level = floor((product + dither difference * 2^15) / 2^47), saturated
  always_comb begin
    if (state == ST_MUL_S) begin
      sum_a = {{2{acc[77]}}, acc[77:6]};
    end else begin
      sum_a = {27'd0, acc[84:38]};
    end
    level_sum = sum_a + {{26{dither_diff[WORD_W]}}, dither_diff, 15'd0};
    level_raw = level_sum[SUM_W-1:47];
    if (level_raw[26:24] == 3'b000 || level_raw[26:24] == 3'b111) begin
      level_sat = level_raw[LEVEL_W-1:0];
    end else if (level_raw[26]) begin
      level_sat = LEVEL_MIN;
    end else begin
      level_sat = LEVEL_MAX;
    end
  end

  // round half up at 2^-17, then saturate to Q1.31
  always_comb begin
    out_rnd = acc[71:0] + 72'd65536;
    out_raw = out_rnd[71:17];
    if ((&out_raw[54:31]) || !(|out_raw[54:31])) begin
      out_sat = out_raw[SAMPLE_W-1:0];
    end else if (out_raw[54]) begin
      out_sat = OUT_MIN;
    end else begin
      out_sat = OUT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      quant_scale     <= QSCALE_RESET;
      out_scale_recip <= RECIP_RESET;
      noise_word      <= SEED_RESET;
      result_valid    <= 1'b0;
      for (int i = 0; i < DITHER_DELAY; i++) begin
        hist[i] <= '0;
      end
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (accept) begin
        hist[0] <= word_next;
        for (int i = 1; i < DITHER_DELAY; i++) begin
          hist[i] <= hist[i-1];
        end
      end

      if (cfg_write && cfg_index == REG_PRNG_SEED) begin
        noise_word <= cfg_data[WORD_W-1:0];
      end else if (accept) begin
        noise_word <= word_next;
      end

      if (cfg_write) begin
        unique case (cfg_index)
          REG_QUANT_SCALE: quant_scale     <= cfg_data[QSCALE_W-1:0];
          REG_OUT_RECIP:   out_scale_recip <= cfg_data[RECIP_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= (sample_in != '0) ? ST_MUL_S : ST_MUL_Z;
          end
        end
        ST_MUL_Z: begin
          if (mul_stat.done) begin
            state <= ST_MUL_T;
          end
        end
        ST_MUL_S, ST_MUL_T: begin
          if (mul_stat.done) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_MUL_O;
        ST_MUL_O: begin
          if (mul_stat.done) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dither_diff <= diff_next;
    end
    if ((state == ST_MUL_S || state == ST_MUL_T) && mul_stat.done) begin
      level <= level_sat;
    end
    if (out_load) begin
      sample_out  <= out_sat;
      quant_level <= level;
    end
  end

  // the multiplier only runs for a sample in flight
  assert property (@(posedge clk) disable iff (rst)
    mul_stat.busy |-> (state == ST_MUL_S || state == ST_MUL_Z ||
                       state == ST_MUL_T || state == ST_MUL_O))
    else $error("multiplier busy outside a multiply state");

  assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == ST_MUL_S || state == ST_MUL_Z ||
                       state == ST_MUL_T || state == ST_MUL_O))
    else $error("multiplier finished with no product awaited");

  // a result only appears from write-back
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_WB))
    else $error("result raised outside write-back");

  // xorshift is a bijection: a nonzero word never steps to zero
  assert property (@(posedge clk) disable iff (rst)
    (accept && noise_word != '0 && !cfg_write) |=> (noise_word != '0))
    else $error("noise generator collapsed to zero");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> (sample_stall && mul_stat.busy))
    else $error("transfer in did not start the multiplier");

endmodule

// ===== verif/requant_checker.sv =====
// Transfer monitor, prediction and result comparison for the dither requantiser.
module requant_checker
  import hptdq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       sample_valid,
  input  logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       result_valid,
  input  logic                       result_stall,
  input  logic signed [SAMPLE_W-1:0] sample_out,
  input  logic signed [LEVEL_W-1:0]  quant_level,
  output int                         mismatches,
  output int                         awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                DELAY        = DITHER_DELAY_DEF;
  localparam logic [95:0]        SUBST_FACTOR = 96'd7132662;
  localparam logic signed [95:0] LVL_HI       = 96'sd16777215;
  localparam logic signed [95:0] LVL_LO       = -96'sd16777216;
  localparam logic signed [95:0] OUT_HI       = 96'sd2147483647;
  localparam logic signed [95:0] OUT_LO       = -96'sd2147483648;
  localparam logic signed [95:0] HALF_LSB     = 96'sd65536;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [LEVEL_W-1:0]  level;
  } requant_t;

  requant_t          pending_results[$];
  logic [QSCALE_W-1:0] qscale;
  logic [RECIP_W-1:0]  recip;
  logic [WORD_W-1:0]   noise;
  logic [WORD_W-1:0]   dither_hist[DELAY];

  function automatic requant_t requantise(input logic signed [SAMPLE_W-1:0] s);
    logic [WORD_W-1:0]  prev;
    logic [WORD_W-1:0]  w;
    logic signed [95:0] dither;
    logic signed [95:0] acc;
    logic signed [95:0] lvl;
    logic signed [95:0] scaled;
    logic [95:0]        subst;
    requant_t           r;
    int                 i;
    prev = noise;
    w = prev ^ (prev << 13);
    w = w ^ (w >> 17);
    w = w ^ (w << 5);
    noise = w;
    dither = ($signed({64'd0, w}) - $signed({64'd0, dither_hist[DELAY-1]})) <<< 15;
    for (i = DELAY - 1; i > 0; i--) dither_hist[i] = dither_hist[i-1];
    dither_hist[0] = w;
    if (s != 0) begin
      acc = $signed({{64{s[31]}}, s}) * $signed({56'd0, qscale}) + dither;
    end else begin
      // zero input replaced by a tiny non-negative value from the old word
      subst = ({64'd0, prev} * SUBST_FACTOR) >> 16;
      subst = (subst * {56'd0, qscale}) >> 32;
      acc = $signed(subst) + dither;
    end
    lvl = acc >>> 47;
    if (lvl > LVL_HI) lvl = LVL_HI;
    if (lvl < LVL_LO) lvl = LVL_LO;
    scaled = (lvl * $signed({50'd0, recip}) + HALF_LSB) >>> 17;
    if (scaled > OUT_HI) scaled = OUT_HI;
    if (scaled < OUT_LO) scaled = OUT_LO;
    r.sample = scaled[SAMPLE_W-1:0];
    r.level  = lvl[LEVEL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    requant_t want;
    int       i;
    if (rst) begin
      qscale = QSCALE_RESET;
      recip  = RECIP_RESET;
      noise  = SEED_RESET;
      for (i = 0; i < DELAY; i++) dither_hist[i] = '0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_QUANT_SCALE: qscale = cfg_data[QSCALE_W-1:0];
          REG_OUT_RECIP:   recip  = cfg_data[RECIP_W-1:0];
          REG_PRNG_SEED:   noise  = cfg_data[WORD_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, got sample_out %0d quant_level %0d",
                   $time, sample_out, quant_level);
        end else begin
          want = pending_results.pop_front();
          if (sample_out !== want.sample) begin
            mismatches++;
            $display("%0t sample_out mismatch: expected %0d, got %0d",
                     $time, want.sample, sample_out);
          end
          if (quant_level !== want.level) begin
            mismatches++;
            $display("%0t quant_level mismatch: expected %0d, got %0d",
                     $time, want.level, quant_level);
          end
        end
      end
      if (sample_valid && !sample_stall) pending_results.push_back(requantise(sample_in));
    end
    awaited = pending_results.size();
  end

endmodule

// ===== verif/highpass_tpdf_dither_quantizer_unit_test.sv =====
// Stimulus, idling and verdict for the dither requantiser testbench.
module highpass_tpdf_dither_quantizer_unit_test
  import hptdq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 160;
  localparam int MAX_GAP       = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [CFG_DATA_W-1:0] QS_MIN     = 46'd7;
  localparam logic [CFG_DATA_W-1:0] QS_16BIT   = 46'd2147483648;
  localparam logic [CFG_DATA_W-1:0] QS_24BIT   = 46'd549755813888;
  localparam logic [CFG_DATA_W-1:0] QS_FULL    = 46'hFF_FFFF_FFFF;
  localparam logic [CFG_DATA_W-1:0] RECIP_24   = 46'd33554432;
  localparam logic [CFG_DATA_W-1:0] RECIP_16   = 46'd8589934592;
  localparam logic [CFG_DATA_W-1:0] RECIP_TOP  = 46'd35184372088832;
  localparam logic [CFG_DATA_W-1:0] RECIP_FULL = 46'h3FFF_FFFF_FFFF;

  logic                       clk = 1'b1;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b1;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic signed [LEVEL_W-1:0]  quant_level;

  int   mismatches;
  int   pending;
  int   cycles = 0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;

  highpass_tpdf_dither_quantizer_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .quant_level  (quant_level)
  );

  requant_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_in    (sample_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sample_out   (sample_out),
    .quant_level  (quant_level),
    .mismatches   (mismatches),
    .awaited      (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("highpass_tpdf_dither_quantizer_unit_test failed");
      $finish;
    end
  end

  // result side: random hold-off before each transfer, none while rx_calm is set
  initial begin : rx_side
    int hold;
    while (rst) @(negedge clk);
    forever begin
      hold = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      sample_in    <= $urandom();
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_in    <= v;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  // only once the block has drained
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    sample_valid <= 1'b0;
    sample_in    <= $urandom();
    while (pending != 0) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2: v = v >>> 22;
      3, 4: v = v >>> $urandom_range(0, 31);
      default: ;
    endcase
    return v;
  endfunction

  task automatic configure_phase();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: write_reg(REG_QUANT_SCALE, QS_MIN);
      1: write_reg(REG_QUANT_SCALE, QS_16BIT);
      2: write_reg(REG_QUANT_SCALE, QS_24BIT);
      3: write_reg(REG_QUANT_SCALE, CFG_DATA_W'(r % 64'd549755813882 + 64'd7));
      4: write_reg(REG_QUANT_SCALE, CFG_DATA_W'(r));
      default: ;
    endcase
    r = {$urandom(), $urandom()};
    case ($urandom_range(0, 5))
      0: write_reg(REG_OUT_RECIP, RECIP_24);
      1: write_reg(REG_OUT_RECIP, RECIP_16);
      2: write_reg(REG_OUT_RECIP, RECIP_TOP);
      3: write_reg(REG_OUT_RECIP, CFG_DATA_W'(r % 64'd35184338534401 + 64'd33554432));
      4: write_reg(REG_OUT_RECIP, CFG_DATA_W'(r));
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0: write_reg(REG_PRNG_SEED, '0);
      1, 2, 3: write_reg(REG_PRNG_SEED, CFG_DATA_W'($urandom()));
      4: write_reg(REG_UNUSED, CFG_DATA_W'(r));
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int ph;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: full scale, zero substitution, tiny values
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0000_0001);
    send_sample(32'shFFFF_FFFF);
    send_sample(32'sh0000_0000);
    send_sample(32'sh4000_0000);
    send_sample(32'shC000_0000);

    // level and output saturation
    write_reg(REG_QUANT_SCALE, QS_FULL);
    write_reg(REG_OUT_RECIP, RECIP_TOP);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0080_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'shFFFF_FFFF);

    // zero seed: generator stuck at zero, history drains
    write_reg(REG_QUANT_SCALE, QS_MIN);
    write_reg(REG_OUT_RECIP, RECIP_FULL);
    write_reg(REG_PRNG_SEED, '0);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);

    write_reg(REG_PRNG_SEED, 46'hFFFF_FFFF);
    send_sample(32'sh0000_0000);
    send_sample(32'sh1234_5678);

    for (ph = 0; ph < PHASES; ph++) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
      configure_phase();
      repeat (PHASE_ITEMS) send_sample(pick_sample());
    end

    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("highpass_tpdf_dither_quantizer_unit_test passed");
    end else begin
      $display("highpass_tpdf_dither_quantizer_unit_test failed");
    end
    $finish;
  end

endmodule
